FILE: src/fppa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fppa_pkg: shared types and constants for the flow priority pipe arbiter.
// Holds the status codes, the queue key layout and the sequencer states.
// ----------------------------------------------------------------------------
package fppa_pkg;

    localparam int QueueDepthDefault = 64;
    localparam int KeyW = 48;

    typedef enum logic [2:0] {
        ST_GRANTED  = 3'd0,
        ST_QUEUED   = 3'd1,
        ST_HANDED   = 3'd2,
        ST_IDLE_NOW = 3'd3,
        ST_DROPPED  = 3'd4,
        ST_BAD_REL  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_REL_RD,
        S_REL_MV,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

FILE: src/flow_priority_pipe_arbiter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flow_priority_pipe_arbiter: sorted wait queue arbiter for one shared pipe.
// Requests take the free pipe or join a queue kept best-first in one RAM.
// ----------------------------------------------------------------------------
// Usage: one input channel (i_valid / o_stall) carries requests (kind 0) and
// releases (kind 1); one output channel (o_valid / i_stall) returns exactly
// one status transfer per input transfer. One item is worked at a time.
// A grant, drop, bad or idle release goes straight to the output state
// S_OUT. A queued request walks the queue from its tail, reading one entry
// in S_INS_RD and, in S_INS_CMP, moving it down one slot while its key is
// larger than the new one, until its place is found. A handoff reads the head
// and then moves every waiting entry up one slot, alternating S_REL_RD and
// S_REL_MV; each move waits for the registered RAM read.
// Reset clears the pipe state and the queue count; the RAM itself is not
// cleared. While the receiver stalls, the result is held in the output
// register and no new item is accepted.
// ----------------------------------------------------------------------------
module flow_priority_pipe_arbiter #(
    parameter int QUEUE_DEPTH = fppa_pkg::QueueDepthDefault
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire         i_kind,
    input  wire  [7:0]  i_flow_id,
    input  wire  [7:0]  i_flow_priority,
    input  wire  [15:0] i_arrival_tenths,
    input  wire  [15:0] i_transmit_tenths,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_grant_id,
    output logic [7:0]  o_holder_id,
    output logic [6:0]  o_waiting_count
);
    import fppa_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [KeyW-1:0] r_mem [QUEUE_DEPTH];
    logic [KeyW-1:0] r_rdata;

    t_state r_state, n_state;
    logic          r_busy, n_busy;
    logic [7:0]    r_holder, n_holder;
    logic [CW-1:0] r_len, n_len;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [KeyW-1:0] r_key, n_key;
    logic [2:0]    r_status, n_status;
    logic [7:0]    r_grant, n_grant;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [KeyW-1:0] wdata;
    logic          re;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_holder <= '0;
            r_len    <= '0;
        end else begin
            r_state  <= n_state;
            r_busy   <= n_busy;
            r_holder <= n_holder;
            r_len    <= n_len;
        end
        r_ptr    <= n_ptr;
        r_key    <= n_key;
        r_status <= n_status;
        r_grant  <= n_grant;
    end

    always_comb begin
        n_state  = r_state;
        n_busy   = r_busy;
        n_holder = r_holder;
        n_len    = r_len;
        n_ptr    = r_ptr;
        n_key    = r_key;
        n_status = r_status;
        n_grant  = r_grant;
        we    = 1'b0;
        waddr = '0;
        wdata = r_key;
        re    = 1'b0;
        raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_grant = '0;
                    n_state = S_OUT;
                    if (!i_kind) begin
                        if (!r_busy) begin
                            n_busy   = 1'b1;
                            n_holder = i_flow_id;
                            n_grant  = i_flow_id;
                            n_status = ST_GRANTED;
                        end else if (r_len >= CW'(QUEUE_DEPTH)) begin
                            n_status = ST_DROPPED;
                        end else begin
                            n_key = {i_flow_priority, i_arrival_tenths,
                                     i_transmit_tenths, i_flow_id};
                            n_ptr = r_len;
                            n_status = ST_QUEUED;
                            n_state  = S_INS_RD;
                        end
                    end else if (!r_busy) begin
                        n_status = ST_BAD_REL;
                    end else if (r_len == '0) begin
                        n_busy   = 1'b0;
                        n_holder = '0;
                        n_status = ST_IDLE_NOW;
                    end else begin
                        re    = 1'b1;
                        raddr = '0;
                        n_ptr = CW'(1);
                        n_status = ST_HANDED;
                        n_state  = S_REL_RD;
                    end
                end
            end
            // r_ptr is the free slot; compare the entry just below it.
            S_INS_RD: begin
                if (r_ptr == '0) begin
                    we    = 1'b1;
                    waddr = AW'(r_ptr);
                    wdata = r_key;
                    n_len = r_len + CW'(1);
                    n_state = S_OUT;
                end else begin
                    re    = 1'b1;
                    raddr = AW'(r_ptr - CW'(1));
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                we    = 1'b1;
                waddr = AW'(r_ptr);
                if (r_rdata <= r_key) begin
                    wdata = r_key;
                    n_len = r_len + CW'(1);
                    n_state = S_OUT;
                end else begin
                    wdata = r_rdata;
                    n_ptr = r_ptr - CW'(1);
                    n_state = S_INS_RD;
                end
            end
            S_REL_RD: begin
                // First pass: r_rdata holds the head; later: entry r_ptr-1.
                if (r_ptr == CW'(1)) begin
                    n_holder = r_rdata[7:0];
                    n_grant  = r_rdata[7:0];
                end else begin
                    we    = 1'b1;
                    waddr = AW'(r_ptr - CW'(2));
                    wdata = r_rdata;
                end
                if (r_ptr >= r_len) begin
                    n_len   = r_len - CW'(1);
                    n_state = S_OUT;
                end else begin
                    re    = 1'b1;
                    raddr = AW'(r_ptr);
                    n_ptr = r_ptr + CW'(1);
                    n_state = S_REL_MV;
                end
            end
            S_REL_MV: begin
                n_state = S_REL_RD;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = (r_state == S_OUT);
    assign o_status        = r_status;
    assign o_grant_id      = r_grant;
    assign o_holder_id     = r_busy ? r_holder : 8'd0;
    assign o_waiting_count = 7'(r_len);

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the flow priority pipe arbiter.
// Drives requests and releases with random bursts and output stalls, keeps
// its own sorted wait queue to predict each status transfer, and compares.
// ----------------------------------------------------------------------------

class arb_scoreboard;
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] grant;
        logic [7:0] holder;
        logic [6:0] count;
    } t_expect;

    bit          busy;
    logic [7:0]  holder;
    logic [47:0] waiting[$];
    t_expect     pending[$];
    int          errors;
    int          depth;

    function new(int d);
        depth = d;
        busy = 0;
        holder = 0;
        errors = 0;
    endfunction

    function void push(fppa_pkg::t_status st, logic [7:0] g);
        t_expect e;
        e.status = st;
        e.grant = g;
        e.holder = busy ? holder : 8'd0;
        e.count = 7'(waiting.size());
        pending.push_back(e);
    endfunction

    // Predict the status transfer caused by one accepted input transfer.
    function void note_input(logic kind, logic [7:0] id, logic [7:0] prio,
                             logic [15:0] arr, logic [15:0] tx);
        logic [47:0] key;
        int pos;
        key = {prio, arr, tx, id};
        pos = 0;
        if (kind == 1'b0) begin
            if (!busy) begin
                busy = 1;
                holder = id;
                push(fppa_pkg::ST_GRANTED, id);
            end else if (waiting.size() >= depth) begin
                push(fppa_pkg::ST_DROPPED, 8'd0);
            end else begin
                // Equal keys go behind the ones already waiting.
                while (pos < waiting.size() && waiting[pos] <= key) pos++;
                waiting.insert(pos, key);
                push(fppa_pkg::ST_QUEUED, 8'd0);
            end
        end else if (!busy) begin
            push(fppa_pkg::ST_BAD_REL, 8'd0);
        end else if (waiting.size() == 0) begin
            busy = 0;
            holder = 0;
            push(fppa_pkg::ST_IDLE_NOW, 8'd0);
        end else begin
            holder = waiting[0][7:0];
            void'(waiting.pop_front());
            push(fppa_pkg::ST_HANDED, holder);
        end
    endfunction

    task report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task check_result(logic [2:0] st, logic [7:0] g, logic [7:0] h,
                      logic [6:0] c);
        t_expect e;
        if (pending.size() == 0) begin
            report("unexpected transfer status", st, -1);
            return;
        end
        e = pending.pop_front();
        if (st !== e.status) report("status", st, e.status);
        if (g !== e.grant) report("grant_id", g, e.grant);
        if (h !== e.holder) report("holder_id", h, e.holder);
        if (c !== e.count) report("waiting_count", c, e.count);
    endtask
endclass

module tb_top;
    import fppa_pkg::*;

    localparam int Depth = 64;
    localparam int WatchLimit = 20000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        i_kind = 0;
    logic [7:0]  i_flow_id = 0;
    logic [7:0]  i_flow_priority = 0;
    logic [15:0] i_arrival_tenths = 0;
    logic [15:0] i_transmit_tenths = 0;
    logic        i_stall = 0;
    logic        o_stall;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [7:0]  o_grant_id;
    logic [7:0]  o_holder_id;
    logic [6:0]  o_waiting_count;

    arb_scoreboard board = new(Depth);
    bit  hold_off = 0;
    bit  sending_done = 0;
    int  idle_cycles = 0;

    flow_priority_pipe_arbiter #(.QUEUE_DEPTH(Depth)) u_top (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            board.note_input(i_kind, i_flow_id, i_flow_priority,
                             i_arrival_tenths, i_transmit_tenths);
        if (i_rst_n && o_valid && !i_stall)
            board.check_result(o_status, o_grant_id, o_holder_id, o_waiting_count);
    end

    // Receiver stall pattern; a hold-off forces a full stall.
    int stall_mode = 0;
    always @(posedge i_clk) begin
        if (hold_off) begin
            i_stall <= 1'b1;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                default: i_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && !(i_valid && !o_stall) && !(o_valid && !i_stall)) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchLimit) begin
                $display("*** FAILED ***");
                $finish;
            end
        end else begin
            idle_cycles <= 0;
        end
    end

    // Offer one item and keep it steady until it is taken.
    task automatic send_item(logic kind, logic [7:0] id, logic [7:0] prio,
                             logic [15:0] arr, logic [15:0] tx);
        i_valid <= 1'b1;
        i_kind <= kind;
        i_flow_id <= id;
        i_flow_priority <= prio;
        i_arrival_tenths <= arr;
        i_transmit_tenths <= tx;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic pause_sender(int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_random(int rel_pct, int narrow);
        logic [7:0]  p;
        logic [15:0] a;
        logic [15:0] t;
        p = narrow ? 8'($urandom_range(0, 3)) : 8'($urandom);
        a = narrow ? 16'($urandom_range(0, 3)) : 16'($urandom);
        t = narrow ? 16'($urandom_range(0, 3)) : 16'($urandom);
        send_item($urandom_range(0, 99) < rel_pct, 8'($urandom), p, a, t);
    endtask

    initial begin
        int burst;
        int sent;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: idle release, grant, ties, extremes, handoffs, idle.
        send_item(1'b1, 8'd0, 8'd0, 16'd0, 16'd0);
        send_item(1'b0, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF);
        send_item(1'b0, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF);
        send_item(1'b0, 8'd0, 8'd0, 16'd0, 16'd0);
        send_item(1'b0, 8'd7, 8'd5, 16'd10, 16'd20);
        send_item(1'b0, 8'd7, 8'd5, 16'd10, 16'd20);
        send_item(1'b0, 8'd6, 8'd5, 16'd10, 16'd20);
        send_item(1'b0, 8'd9, 8'd5, 16'd10, 16'd19);
        send_item(1'b0, 8'd3, 8'd5, 16'd9, 16'hFFFF);
        send_item(1'b0, 8'd255, 8'd0, 16'd0, 16'd0);
        repeat (10) send_item(1'b1, 8'd0, 8'd0, 16'd0, 16'd0);

        // Fill the queue past full; the receiver is held off for a while first.
        send_item(1'b0, 8'd1, 8'd1, 16'd1, 16'd1);
        hold_off = 1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
            for (int k = 0; k < Depth + 3; k++) send_random(0, 1);
        join
        hold_off = 0;
        for (int k = 0; k < Depth + 2; k++) send_random(100, 0);

        // Random bursts; mix of release rates keeps the queue moving.
        sent = 0;
        while (sent < 1300) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++) begin
                send_random((sent / 200) % 2 ? 30 : 55, $urandom_range(0, 1));
                sent++;
            end
            if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 20));
        end
        i_valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

FILE: files.f
src/fppa_pkg.sv
src/flow_priority_pipe_arbiter.sv
tb/sv/tb_top.sv
